>>> rtl/swar_pkg.sv
// swar_pkg: shared types and constants of the sliding window autorange block
// register indexes, scale mode codes, controller states, command and status words
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package swar_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int SMP_W     = 32;
    localparam int HIST_W    = 9;
    localparam int MODE_W    = 2;
    localparam int RATE_W    = 17;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_HISTORY = 3'd0;
    localparam logic [IDX_W-1:0] REG_MODE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_RATE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_INIT_LO = 3'd3;
    localparam logic [IDX_W-1:0] REG_INIT_HI = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FIXED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXPAND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

    localparam logic [HIST_W-1:0] HIST_RST    = 9'd256;
    localparam logic [RATE_W-1:0] RATE_RST    = 17'd6554;
    localparam logic [RATE_W-1:0] RATE_ONE    = 17'd65536;
    localparam logic [SMP_W-1:0]  INIT_LO_RST = 32'd0;
    localparam logic [SMP_W-1:0]  INIT_HI_RST = 32'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_DRAIN,
        ST_MUL_LO,
        ST_ADD_LO,
        ST_MUL_HI,
        ST_ADD_HI,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [SMP_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic load_sample;
        logic write;
        logic scan_rd;
        logic mul;
        logic add;
        logic sel_hi;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic auto_scan;
        logic scan_none;
        logic scan_last;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/swar_in_if.sv
// swar_in_if: input channel carrying one sample word
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface swar_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> rtl/swar_out_if.sv
// swar_out_if: output channel carrying the scale bounds after each sample
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface swar_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] scale_low;
    logic signed [31:0] scale_high;

    modport source (output valid, output scale_low, output scale_high, input ready);
    modport sink   (input valid, input scale_low, input scale_high, output ready);
endinterface

`default_nettype wire

>>> rtl/swar_ctrl.sv
// swar_ctrl: sequencing state machine of the autorange block
// drives datapath commands from its status, owns the handshakes; uses swar_pkg
`timescale 1ns / 1ps
`default_nettype none

module swar_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire swar_pkg::t_status i_status,
    output swar_pkg::t_cmd       o_cmd
);
    import swar_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (!i_status.auto_scan) n_state = ST_DONE;
                else if (i_status.scan_none) n_state = ST_MUL_LO;
                else n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN:  n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_ADD_LO;
            ST_ADD_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_ADD_HI;
            ST_ADD_HI: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_sample = i_in_valid;
            end
            ST_WRITE:  o_cmd.write   = 1'b1;
            ST_SCAN:   o_cmd.scan_rd = 1'b1;
            ST_DRAIN:  o_cmd         = '0;
            ST_MUL_LO: o_cmd.mul     = 1'b1;
            ST_ADD_LO: o_cmd.add     = 1'b1;
            ST_MUL_HI: begin
                o_cmd.mul    = 1'b1;
                o_cmd.sel_hi = 1'b1;
            end
            ST_ADD_HI: begin
                o_cmd.add    = 1'b1;
                o_cmd.sel_hi = 1'b1;
            end
            ST_DONE:   o_cmd.out_load = out_free;
            default:   o_cmd          = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/swar_datapath.sv
// swar_datapath: sample ring, window scan, smoothing multiplier and scale registers
// also holds the configuration registers and the result word; uses swar_pkg
`timescale 1ns / 1ps
`default_nettype none

module swar_datapath #(
    parameter int WINDOW_DEPTH = swar_pkg::DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire swar_pkg::t_cfg_wr    i_cfg,
    input  wire swar_pkg::t_cmd       i_cmd,
    output swar_pkg::t_status         o_status,
    input  wire logic signed [31:0]   i_sample,
    output logic signed [31:0]        o_scale_low,
    output logic signed [31:0]        o_scale_high
);
    import swar_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic signed [SMP_W-1:0] r_mem [WINDOW_DEPTH];
    logic signed [SMP_W-1:0] r_rd_data;
    logic                    r_rd_live;
    logic                    r_fold;

    logic [HIST_W-1:0]       r_hist;
    logic [MODE_W-1:0]       r_mode;
    logic [RATE_W-1:0]       r_rate;
    logic signed [SMP_W-1:0] r_smin;
    logic signed [SMP_W-1:0] r_smax;
    logic signed [SMP_W-1:0] r_sample;
    logic signed [SMP_W-1:0] r_lo;
    logic signed [SMP_W-1:0] r_hi;
    logic signed [50:0]      r_prod;
    logic signed [SMP_W-1:0] r_out_low;
    logic signed [SMP_W-1:0] r_out_high;

    logic [AW-1:0]           r_slot;
    logic [AW-1:0]           r_addr;
    logic [CW-1:0]           r_fill;
    logic [CW-1:0]           r_left;

    logic [CW-1:0]           count;
    logic                    active;
    logic [RATE_W-1:0]       rate_eff;
    logic signed [32:0]      diff;
    logic signed [50:0]      n_prod;
    logic signed [SMP_W-1:0] bound;
    logic signed [33:0]      step;
    logic signed [33:0]      sum;
    logic signed [SMP_W-1:0] fold_val;
    logic [AW-1:0]           slot_prev;
    logic [AW-1:0]           addr_prev;

    always_comb begin
        if (32'(r_hist) > 32'(WINDOW_DEPTH)) count = CW'(WINDOW_DEPTH);
        else count = CW'(r_hist);
    end

    assign active   = (count != '0);
    assign rate_eff = (r_rate > RATE_ONE) ? RATE_ONE : r_rate;

    assign slot_prev = (r_slot == '0) ? AW'(WINDOW_DEPTH - 1) : r_slot - 1'b1;
    assign addr_prev = (r_addr == '0) ? AW'(WINDOW_DEPTH - 1) : r_addr - 1'b1;

    always_comb begin
        if (i_cmd.sel_hi) diff = {r_hi[31], r_hi} - {r_smax[31], r_smax};
        else diff = {r_lo[31], r_lo} - {r_smin[31], r_smin};
    end

    assign n_prod   = diff * $signed({1'b0, rate_eff});
    assign bound    = i_cmd.sel_hi ? r_smax : r_smin;
    assign step     = r_prod[49:16];
    assign sum      = {{2{bound[31]}}, bound} + step;
    assign fold_val = r_rd_live ? r_rd_data : '0;

    assign o_status.auto_scan = active && (r_mode == MODE_AUTO);
    assign o_status.scan_none = (count == CW'(1));
    assign o_status.scan_last = (r_left == CW'(1));

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && active) r_mem[r_slot] <= r_sample;
        if (i_cmd.scan_rd) r_rd_data <= r_mem[r_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_fill <= '0;
            r_left <= '0;
            r_fold <= 1'b0;
        end else begin
            r_fold <= i_cmd.scan_rd;
            if (i_cmd.write && active) begin
                r_slot <= (r_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                if (r_fill != CW'(WINDOW_DEPTH)) r_fill <= r_fill + 1'b1;
                r_left <= count - 1'b1;
            end else if (i_cmd.scan_rd) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    // configuration and scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= HIST_RST;
            r_mode <= MODE_FIXED;
            r_rate <= RATE_RST;
            r_smin <= INIT_LO_RST;
            r_smax <= INIT_HI_RST;
        end else begin
            priority if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    REG_HISTORY: r_hist <= i_cfg.data[HIST_W-1:0];
                    REG_MODE:    r_mode <= i_cfg.data[MODE_W-1:0];
                    REG_RATE:    r_rate <= i_cfg.data[RATE_W-1:0];
                    REG_INIT_LO: r_smin <= i_cfg.data;
                    REG_INIT_HI: r_smax <= i_cfg.data;
                    default: ;
                endcase
            end else if (i_cmd.write && active && (r_mode == MODE_EXPAND)) begin
                if (r_sample < r_smin) r_smin <= r_sample;
                else if (r_sample > r_smax) r_smax <= r_sample;
            end else if (i_cmd.add) begin
                if (i_cmd.sel_hi) r_smax <= sum[31:0];
                else r_smin <= sum[31:0];
            end
        end
    end

    // scan and payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) r_sample <= i_sample;
        if (i_cmd.write) begin
            r_lo   <= r_sample;
            r_hi   <= r_sample;
            r_addr <= slot_prev;
        end else begin
            if (i_cmd.scan_rd) begin
                r_addr    <= addr_prev;
                r_rd_live <= (32'(r_addr) < 32'(r_fill));
            end
            if (r_fold) begin
                if (fold_val < r_lo) r_lo <= fold_val;
                if (fold_val > r_hi) r_hi <= fold_val;
            end
        end
        if (i_cmd.mul) r_prod <= n_prod;
        if (i_cmd.out_load) begin
            r_out_low  <= r_smin;
            r_out_high <= r_smax;
        end
    end

    assign o_scale_low  = r_out_low;
    assign o_scale_high = r_out_high;

endmodule

`default_nettype wire

>>> rtl/sliding_window_autorange.sv
// sliding_window_autorange: display scale tracker over a sliding sample window
// top level joining swar_ctrl and swar_datapath; uses swar_pkg, swar_in_if, swar_out_if
//
// usage:
//   i_in carries one signed Q16.16 sample word, o_out one word holding the scale
//   bounds after that sample. a word is taken when valid and ready are both high.
//   registers are written on i_cfg_we with i_cfg_idx and i_cfg_data; the user writes
//   only while idle (unchecked); writing initial_min/max loads the scale bound at once.
// sequence:
//   one sample at a time. fixed and auto expand modes, the unused mode code, or a
//   zero history skip the window walk and the multiplier and load the result word.
//   auto scale walks the ring through its single read port one entry a cycle,
//   then runs two multiply and add steps that share one multiplier; the window
//   spans the history, capped at WINDOW_DEPTH, and a history of one skips the walk.
// reset:
//   synchronous, active low; registers return to their defaults and the ring
//   reads as zeros at once through a fill count, no clearing pass.
// stall:
//   the result word waits in an output register; the next sample is accepted
//   meanwhile and its result holds back until the earlier word is taken.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_autorange #(
    parameter int WINDOW_DEPTH = swar_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    swar_in_if.sink                                i_in,
    swar_out_if.source                             o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [swar_pkg::IDX_W-1:0]        i_cfg_idx,
    input  wire logic [swar_pkg::SMP_W-1:0]        i_cfg_data
);
    import swar_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_cfg_wr cfg;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    swar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    swar_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_sample     (i_in.sample),
        .o_scale_low  (o_out.scale_low),
        .o_scale_high (o_out.scale_high)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a sample is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result word overwritten before it was taken");

    a_write_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write |-> $past(i_in.valid && i_in.ready))
        else $error("ring write without an accepted sample");

    a_scan_only_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_rd |-> status.auto_scan)
        else $error("window scan outside auto scale mode");

endmodule

`default_nettype wire

>>> sim/tb.sv
// tb: self-checking testbench for sliding_window_autorange, scale bounds predicted per sample
// drives random and directed samples, register writes and back pressure, checks every result word
// depends on swar_pkg, swar_in_if, swar_out_if and the sliding_window_autorange rtl
`timescale 1ns / 1ps

module tb;
    import swar_pkg::*;

    localparam int DEPTH         = DEPTH_DEF;
    localparam int RAND_ITEMS    = 600;
    localparam int QUIET_ITEMS   = 80;
    localparam int SETTLE_CYCLES = DEPTH + 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [IDX_W-1:0]  REG_SPARE_FIRST = 3'd5;
    localparam logic [IDX_W-1:0]  REG_SPARE_LAST  = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE      = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE = 32'sh00010000;

    typedef struct packed {
        logic signed [31:0] low;
        logic signed [31:0] high;
    } t_bounds;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_idx;
    logic [SMP_W-1:0]   cfg_data;

    swar_in_if  in_ch ();
    swar_out_if out_ch ();

    sliding_window_autorange dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // predictor state
    logic signed [31:0] win_ring [DEPTH];
    int unsigned        ring_wr;
    logic signed [31:0] bound_lo;
    logic signed [31:0] bound_hi;
    logic [HIST_W-1:0]  hist_len;
    logic [MODE_W-1:0]  mode_sel;
    logic [RATE_W-1:0]  rate_q16;

    t_bounds scale_expect_q [$];
    t_bounds got_w;
    t_bounds want_w;

    int  mismatches;
    int  quiet_cnt;
    bit  tx_idle_en;
    bit  rx_idle_en;
    bit  hold_req;
    bit  sent_since_cfg;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic signed [31:0] glide(input logic signed [31:0] bound,
                                                 input logic signed [31:0] target,
                                                 input logic [RATE_W-1:0]  r);
        longint d;
        longint p;
        d = longint'(target) - longint'(bound);
        p = d * longint'(r);
        return 32'(longint'(bound) + (p >>> 16));
    endfunction

    task automatic predict_bounds(input logic signed [31:0] s);
        int unsigned        span;
        int unsigned        idx;
        int unsigned        k;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic [RATE_W-1:0]  r;
        t_bounds            b;
        span = (hist_len > DEPTH) ? DEPTH : hist_len;
        if (span != 0) begin
            win_ring[ring_wr] = s;
            idx = ring_wr;
            ring_wr = (ring_wr + 1) % DEPTH;
            if (mode_sel == MODE_EXPAND) begin
                if (s < bound_lo) begin
                    bound_lo = s;
                end else if (s > bound_hi) begin
                    bound_hi = s;
                end
            end else if (mode_sel == MODE_AUTO) begin
                lo = Q_MAX;
                hi = Q_MIN;
                for (k = 0; k < span; k++) begin
                    if (win_ring[idx] < lo) lo = win_ring[idx];
                    if (win_ring[idx] > hi) hi = win_ring[idx];
                    idx = (idx == 0) ? DEPTH - 1 : idx - 1;
                end
                r = (rate_q16 > RATE_ONE) ? RATE_ONE : rate_q16;
                bound_lo = glide(bound_lo, lo, r);
                bound_hi = glide(bound_hi, hi, r);
            end
        end
        b.low  = bound_lo;
        b.high = bound_hi;
        scale_expect_q.insert(scale_expect_q.size(), b);
    endtask

    task automatic push_sample(input logic signed [31:0] s);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_bounds(s);
        sent_since_cfg = 1'b1;
    endtask

    // drain all words, then let the block go quiet if any sample went in since the last settle
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (scale_expect_q.size() != 0) @(posedge i_clk);
        if (sent_since_cfg) repeat (SETTLE_CYCLES) @(posedge i_clk);
        sent_since_cfg = 1'b0;
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [SMP_W-1:0] data);
        settle();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HISTORY: hist_len = data[HIST_W-1:0];
            REG_MODE:    mode_sel = data[MODE_W-1:0];
            REG_RATE:    rate_q16 = data[RATE_W-1:0];
            REG_INIT_LO: bound_lo = data;
            REG_INIT_HI: bound_hi = data;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
        endcase
    endfunction

    task automatic random_config();
        logic [HIST_W-1:0] h;
        logic [RATE_W-1:0] r;
        case ($urandom_range(0, 9))
            0: h = '0;
            1: h = HIST_W'($urandom_range(DEPTH - 4, (1 << HIST_W) - 1));
            default: h = HIST_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 4))
            0: r = '0;
            1: r = RATE_ONE;
            2: r = RATE_W'($urandom);
            default: r = RATE_W'($urandom_range(1, 32'h8000));
        endcase
        reg_write(REG_HISTORY, ($urandom & ~32'h1ff) | 32'(h));
        reg_write(REG_MODE, ($urandom & ~32'h3) | 32'($urandom_range(0, 3)));
        reg_write(REG_RATE, ($urandom & ~32'h1ffff) | 32'(r));
        if ($urandom_range(0, 2) == 0) begin
            reg_write(REG_INIT_LO, $urandom_range(0, 5) == 0 ? Q_MIN : pick_sample());
            reg_write(REG_INIT_HI, $urandom_range(0, 5) == 0 ? Q_MAX : pick_sample());
        end
    endtask

    task automatic test_fixed_defaults();
        push_sample(Q_MAX);
        push_sample(Q_MIN);
        push_sample(32'sd0);
        push_sample(-32'sd1);
    endtask

    task automatic test_auto_expand();
        reg_write(REG_MODE, 32'(MODE_EXPAND));
        push_sample(-32'sd5 * Q_ONE);
        push_sample(32'sd3 * Q_ONE);
        push_sample(32'sd100);
        push_sample(Q_MAX);
        push_sample(Q_MIN);
    endtask

    task automatic test_auto_scale();
        reg_write(REG_HISTORY, 32'd4);
        reg_write(REG_MODE, 32'(MODE_AUTO));
        reg_write(REG_RATE, 32'(RATE_ONE));
        push_sample(32'sd7 * Q_ONE);
        push_sample(-32'sd2 * Q_ONE);
        reg_write(REG_RATE, 32'd0);
        push_sample(Q_MAX);
        reg_write(REG_RATE, 32'h1ffff);
        push_sample(32'sd1);
        reg_write(REG_RATE, 32'(RATE_RST));
        push_sample(Q_MIN);
        push_sample(Q_MAX);
    endtask

    task automatic test_zero_history();
        reg_write(REG_HISTORY, 32'd0);
        push_sample(Q_MIN);
        push_sample(Q_MAX);
    endtask

    task automatic test_oversized_history();
        reg_write(REG_HISTORY, 32'h1ff);
        reg_write(REG_RATE, 32'h8000);
        push_sample(32'sd9 * Q_ONE);
        push_sample(-32'sd9 * Q_ONE);
    endtask

    task automatic test_history_change();
        reg_write(REG_HISTORY, 32'd8);
        push_sample(32'sd4 * Q_ONE);
        reg_write(REG_HISTORY, 32'd2);
        push_sample(-32'sd1 * Q_ONE);
        reg_write(REG_HISTORY, 32'd200);
        push_sample(32'sd0);
    endtask

    task automatic test_scale_writes();
        reg_write(REG_MODE, 32'(MODE_FIXED));
        reg_write(REG_INIT_LO, 32'sd10 * Q_ONE);
        reg_write(REG_INIT_HI, -32'sd10 * Q_ONE);
        push_sample(32'sd5 * Q_ONE);
        reg_write(REG_MODE, 32'(MODE_EXPAND));
        push_sample(32'sd0);
        reg_write(REG_MODE, 32'(MODE_AUTO));
        push_sample(32'sd3 * Q_ONE);
    endtask

    task automatic test_unused_codes();
        logic [IDX_W-1:0] idx;
        reg_write(REG_MODE, 32'(MODE_SPARE));
        push_sample(Q_MIN);
        for (idx = REG_SPARE_FIRST; idx != REG_HISTORY; idx++) begin
            reg_write(idx, $urandom);
        end
        reg_write(REG_MODE, 32'(MODE_EXPAND));
        push_sample(32'sd2 * Q_ONE);
        reg_write(REG_SPARE_LAST, $urandom);
    endtask

    task automatic test_back_pressure();
        int k;
        reg_write(REG_HISTORY, 32'd3);
        reg_write(REG_MODE, 32'(MODE_FIXED));
        settle();
        hold_req = 1'b1;
        for (k = 0; k < 16; k++) push_sample(pick_sample());
        reg_write(REG_MODE, 32'(MODE_AUTO));
        hold_req = 1'b1;
        for (k = 0; k < 8; k++) push_sample(pick_sample());
    endtask

    task automatic test_random();
        int sent;
        int phase_len;
        int k;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            random_config();
            phase_len = $urandom_range(20, 60);
            for (k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
                if (sent >= RAND_ITEMS - QUIET_ITEMS) begin
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                push_sample(pick_sample());
                sent++;
            end
        end
    endtask

    // result receiver
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_w.low  = out_ch.scale_low;
            got_w.high = out_ch.scale_high;
            if (scale_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: low %0d high %0d", got_w.low, got_w.high);
            end else begin
                want_w = scale_expect_q[0];
                scale_expect_q.delete(0);
                if (got_w.low !== want_w.low || got_w.high !== want_w.high) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word mismatch: low exp %0d got %0d, high exp %0d got %0d",
                                 want_w.low, got_w.low, want_w.high, got_w.high);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cnt = 0;
        end else begin
            quiet_cnt++;
        end
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("sliding_window_autorange: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        in_ch.valid    = 1'b0;
        in_ch.sample   = '0;
        mismatches     = 0;
        quiet_cnt      = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        hold_req       = 1'b0;
        sent_since_cfg = 1'b0;
        foreach (win_ring[i]) win_ring[i] = '0;
        ring_wr  = 0;
        hist_len = HIST_RST;
        mode_sel = MODE_FIXED;
        rate_q16 = RATE_RST;
        bound_lo = INIT_LO_RST;
        bound_hi = INIT_HI_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fixed_defaults();
        test_auto_expand();
        test_auto_scale();
        test_zero_history();
        test_oversized_history();
        test_history_change();
        test_scale_writes();
        test_unused_codes();
        test_back_pressure();
        test_random();

        sent_since_cfg = 1'b1;
        settle();
        if (mismatches == 0 && scale_expect_q.size() == 0) begin
            $display("sliding_window_autorange: match");
        end else begin
            $display("sliding_window_autorange: mismatch");
        end
        $finish;
    end

endmodule
